>>> src/csg_pkg.sv
// Shared types and constants for the complex spatio-temporal gradient unit.
// No dependencies.
package csg_pkg;

  localparam int OUT_W     = 17;  // width of every result field
  localparam int CFG_W     = 11;  // width of the configuration registers
  localparam int CFG_IDX_W = 2;   // width of the configuration register index
  localparam int LINES     = 5;   // rows held by the line store
  localparam int BANK_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic ACT_FLUSH = 1'b1;

  typedef logic [BANK_W-1:0] bank_t;

  // Stage advance strobes for the arithmetic pipeline.
  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
  } stage_en_t;

  // Per-result control carried alongside the data.
  typedef struct packed {
    logic  interior;
    logic  frame_end;
    bank_t bank;
  } ctrl_t;

  // Row bank offset modulo the number of lines.
  function automatic bank_t bank_add(bank_t b, bank_t k);
    logic [BANK_W:0] s;
    s = {1'b0, b} + {1'b0, k};
    return (s >= (BANK_W+1)'(LINES)) ? BANK_W'(s - (BANK_W+1)'(LINES)) : BANK_W'(s);
  endfunction

endpackage

>>> src/csg_in_if.sv
// Input channel of the gradient unit: one pixel or flush beat.
// No dependencies.
interface csg_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic signed [SAMPLE_BITS-1:0] curr_re;
  logic signed [SAMPLE_BITS-1:0] curr_im;
  logic signed [SAMPLE_BITS-1:0] prev_re;
  logic signed [SAMPLE_BITS-1:0] prev_im;

  modport source(output valid, action, curr_re, curr_im, prev_re, prev_im, input ready);
  modport sink(input valid, action, curr_re, curr_im, prev_re, prev_im, output ready);
endinterface

>>> src/csg_out_if.sv
// Result channel of the gradient unit: one gradient beat.
// Depends on csg_pkg.
interface csg_out_if;
  import csg_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] gx_re;
  logic signed [OUT_W-1:0] gx_im;
  logic signed [OUT_W-1:0] gy_re;
  logic signed [OUT_W-1:0] gy_im;
  logic signed [OUT_W-1:0] gt_re;
  logic signed [OUT_W-1:0] gt_im;
  logic                    frame_end;

  modport source(output valid, gx_re, gx_im, gy_re, gy_im, gt_re, gt_im, frame_end,
                 input ready);
  modport sink(input valid, gx_re, gx_im, gy_re, gy_im, gt_re, gt_im, frame_end,
               output ready);
endinterface

>>> src/csg_line_store.sv
// Five-row line store, one bank per row, one write and two read ports per bank.
// Depends on csg_pkg.
module csg_line_store #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  csg_pkg::bank_t                               wr_bank,
  input  logic [$clog2(MAX_WIDTH)-1:0]                 wr_col,
  input  logic [2*SAMPLE_BITS-1:0]                     wr_data,
  input  logic                                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]                 rd_col_a,
  input  logic [$clog2(MAX_WIDTH)-1:0]                 rd_col_b,
  output logic [csg_pkg::LINES-1:0][2*SAMPLE_BITS-1:0] rd_a,
  output logic [csg_pkg::LINES-1:0][2*SAMPLE_BITS-1:0] rd_b
);
  import csg_pkg::*;

  localparam int D_W = 2 * SAMPLE_BITS;

  for (genvar g = 0; g < LINES; g++) begin : g_bank
    logic [D_W-1:0] mem [MAX_WIDTH];

    always_ff @(posedge clk) begin
      if (wr_en && wr_bank == BANK_W'(g)) begin
        mem[wr_col] <= wr_data;
      end
      if (rd_en) begin
        rd_a[g] <= mem[rd_col_a];
        rd_b[g] <= mem[rd_col_b];
      end
    end
  end

endmodule

>>> src/csg_diff_delay.sv
// Ring of pending temporal differences with fill count.
// Depends on csg_pkg.
module csg_diff_delay #(
  parameter int DEPTH = 2051,
  parameter int D_W   = 34
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clear,
  input  logic                       push,
  input  logic [D_W-1:0]             wr_data,
  input  logic                       pop,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic [D_W-1:0]             rd_data
);
  import csg_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [D_W-1:0]   mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else if (clear) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // write and read never meet at one slot: the read is always an older entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
    if (pop) begin
      rd_data <= mem[rd_ptr_r];
    end
  end

endmodule

>>> src/csg_stencil.sv
// Five-point central difference (a - 8b + 8c - d) / 12, truncated toward zero.
// Three stages: sum, scaled magnitude, quotient. Depends on csg_pkg.
module csg_stencil #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  csg_pkg::stage_en_t                   en,
  input  logic signed [SAMPLE_BITS-1:0]        a,
  input  logic signed [SAMPLE_BITS-1:0]        b,
  input  logic signed [SAMPLE_BITS-1:0]        c,
  input  logic signed [SAMPLE_BITS-1:0]        d,
  input  logic                                 keep,
  output logic signed [csg_pkg::OUT_W-1:0]     res
);
  import csg_pkg::*;

  localparam int SW    = SAMPLE_BITS + 5;   // sum width
  localparam int MAG_W = SW - 1;
  localparam int K     = SAMPLE_BITS + 8;   // reciprocal shift
  localparam int M_W   = K - 3;
  localparam logic [M_W-1:0] RECIP = M_W'(((64'd1 << K) + 64'd11) / 64'd12);
  localparam int P_W   = MAG_W + M_W;
  localparam int Q_W   = P_W - K;

  logic signed [SW-1:0]    sum_nxt, sum_r;
  logic [SW-1:0]           mag_full;
  logic [P_W-1:0]          prod_r;
  logic                    neg_r;
  logic signed [Q_W:0]     quo;

  assign sum_nxt  = SW'(a) - (SW'(b) <<< 3) + (SW'(c) <<< 3) - SW'(d);
  assign mag_full = sum_r[SW-1] ? -sum_r : sum_r;
  assign quo      = $signed({1'b0, prod_r[P_W-1:K]});

  always_ff @(posedge clk) begin
    if (en.en2) begin
      sum_r <= sum_nxt;
    end
    if (en.en3) begin
      neg_r  <= sum_r[SW-1];
      prod_r <= P_W'(mag_full[MAG_W-1:0]) * P_W'(RECIP);
    end
    if (en.en4) begin
      res <= keep ? OUT_W'(neg_r ? -quo : quo) : '0;
    end
  end

endmodule

>>> src/complex_spatiotemporal_gradient_unit.sv
// Complex spatio-temporal gradient unit: top level.
// Depends on csg_pkg, csg_in_if, csg_out_if, csg_line_store, csg_diff_delay, csg_stencil.
//
// Usage:
//   in_s carries one beat per pixel in raster order (action 0: current and previous
//   frame sample of the same pixel) or a flush beat (action 1) that drains one
//   pending result. out_m carries horizontal and vertical five-point gradients,
//   the temporal difference and a frame_end flag on the last pixel of a frame.
//   A result belongs to the pixel 2*width+2 pixel beats back; flush beats drain
//   the tail, a flush with nothing pending gives nothing.
//   Throughput: one beat per clock while out_m does not stall, set by the dual read
//   port of each line bank and the single write port. A result passes the memory
//   read, sum, multiply and quotient registers on its way to out_m.
//   cfg_we with cfg_index 0 or 1 sets frame_width or frame_height (0 reads as 1,
//   values above the maximum saturate) and restarts the raster, dropping pending
//   results; write only while idle.
//   Reset (rst_n low, synchronous) sets both dimensions to 1024, clamped to the
//   maximum, and empties the pipeline. Memories are not cleared.
//   When out_m stalls, the stages in front close up; in_s stays ready while a
//   stage is free.
module complex_spatiotemporal_gradient_unit #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  csg_in_if.sink                             in_s,
  csg_out_if.source                          out_m,
  input  logic                               cfg_we,
  input  logic [csg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [csg_pkg::CFG_W-1:0]          cfg_data
);
  import csg_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WW    = COL_W + 1;
  localparam int HW    = ROW_W + 1;
  localparam int SB    = SAMPLE_BITS;
  localparam int D_W   = 2 * SB;
  localparam int T_W   = SB + 1;
  localparam int DEPTH = 2 * MAX_WIDTH + 3;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // clamp a register write to the usable range
  function automatic logic [WW-1:0] sat_w(logic [CFG_W-1:0] v);
    if (v == '0) return WW'(1);
    if (32'(v) > MAX_WIDTH) return WW'(MAX_WIDTH);
    return WW'(v);
  endfunction

  function automatic logic [HW-1:0] sat_h(logic [CFG_W-1:0] v);
    if (v == '0) return HW'(1);
    if (32'(v) > MAX_HEIGHT) return HW'(MAX_HEIGHT);
    return HW'(v);
  endfunction

  // dimensions and raster positions
  logic [WW-1:0]    eff_w_r;
  logic [HW-1:0]    eff_h_r;
  logic [COL_W-1:0] in_col_r, out_col_r;
  logic [ROW_W-1:0] in_row_r, out_row_r;
  bank_t            in_bank_r, out_bank_r;

  // handshake and stage control
  logic      accept, is_flush, pix, emit, cfg_hit;
  logic      en1, en2, en3, en4;
  logic      v1_r, v2_r, v3_r, out_valid_r;
  stage_en_t sen;
  ctrl_t     ctrl0, c1_r, c2_r, c3_r;

  // memories
  logic [CNT_W-1:0]            count;
  logic [2*T_W-1:0]            dd_wr, dd_rd;
  logic [LINES-1:0][D_W-1:0]   ls_a, ls_b;
  logic [T_W-1:0]              diff_re, diff_im;

  // row history for the horizontal stencil
  logic [D_W-1:0] ha1_r, hb1_r, hb2_r;
  logic [D_W-1:0] sel_a, sel_b, vm2, vm1, vp1, vp2;

  // temporal difference pipeline
  logic signed [OUT_W-1:0] dt2_re_r, dt2_im_r, dt3_re_r, dt3_im_r;
  logic signed [OUT_W-1:0] gt_re_r, gt_im_r;
  logic                    frame_end_r;

  logic in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap;

  assign en4 = !out_valid_r || out_m.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign sen = '{en2: en2, en3: en3, en4: en4};

  assign in_s.ready = en1;
  assign accept     = in_s.valid && en1;
  assign is_flush   = in_s.action == ACT_FLUSH;
  assign pix        = accept && !is_flush;
  // a pixel beat releases the oldest result once 2*width+2 are pending
  assign emit = accept && (is_flush ? (count != '0)
                                    : (count >= CNT_W'({eff_w_r, 1'b0} + (WW+1)'(2))));
  assign cfg_hit = cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  assign in_col_wrap  = (WW'(in_col_r) + WW'(1)) >= eff_w_r;
  assign in_row_wrap  = (HW'(in_row_r) + HW'(1)) >= eff_h_r;
  assign out_col_wrap = (WW'(out_col_r) + WW'(1)) >= eff_w_r;
  assign out_row_wrap = (HW'(out_row_r) + HW'(1)) >= eff_h_r;

  always_comb begin
    ctrl0.bank      = out_bank_r;
    ctrl0.frame_end = out_col_wrap && out_row_wrap;
    ctrl0.interior  = (out_col_r >= COL_W'(2)) &&
                      ((WW'(out_col_r) + WW'(2)) < eff_w_r) &&
                      (out_row_r >= ROW_W'(2)) &&
                      ((HW'(out_row_r) + HW'(2)) < eff_h_r);
  end

  // raster counters and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r    <= sat_w(CFG_W'(1024));
      eff_h_r    <= sat_h(CFG_W'(1024));
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_bank_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_bank_r <= '0;
    end else if (cfg_hit) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        eff_w_r <= sat_w(cfg_data);
      end else begin
        eff_h_r <= sat_h(cfg_data);
      end
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_bank_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_bank_r <= '0;
    end else begin
      if (pix) begin
        if (in_col_wrap) begin
          in_col_r <= '0;
          if (in_row_wrap) begin
            in_row_r  <= '0;
            in_bank_r <= '0;
          end else begin
            in_row_r  <= in_row_r + ROW_W'(1);
            in_bank_r <= bank_add(in_bank_r, BANK_W'(1));
          end
        end else begin
          in_col_r <= in_col_r + COL_W'(1);
        end
      end
      if (emit) begin
        if (out_col_wrap) begin
          out_col_r <= '0;
          if (out_row_wrap) begin
            out_row_r  <= '0;
            out_bank_r <= '0;
          end else begin
            out_row_r  <= out_row_r + ROW_W'(1);
            out_bank_r <= bank_add(out_bank_r, BANK_W'(1));
          end
        end else begin
          out_col_r <= out_col_r + COL_W'(1);
        end
      end
    end
  end

  // store the pixel; read centre column and two ahead from every bank
  csg_line_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .SAMPLE_BITS(SB)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (pix),
    .wr_bank (in_bank_r),
    .wr_col  (in_col_r),
    .wr_data ({in_s.curr_re, in_s.curr_im}),
    .rd_en   (en1),
    .rd_col_a(out_col_r + COL_W'(2)),
    .rd_col_b(out_col_r),
    .rd_a    (ls_a),
    .rd_b    (ls_b)
  );

  assign diff_re = T_W'(in_s.curr_re) - T_W'(in_s.prev_re);
  assign diff_im = T_W'(in_s.curr_im) - T_W'(in_s.prev_im);
  assign dd_wr   = {diff_re, diff_im};

  csg_diff_delay #(
    .DEPTH(DEPTH),
    .D_W  (2 * T_W)
  ) u_diff_delay (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (cfg_hit),
    .push   (pix),
    .wr_data(dd_wr),
    .pop    (emit),
    .count  (count),
    .rd_data(dd_rd)
  );

  // select the rows of the result out of the banks
  assign sel_a = ls_a[c1_r.bank];
  assign sel_b = ls_b[c1_r.bank];
  assign vm2   = ls_b[bank_add(c1_r.bank, BANK_W'(3))];
  assign vm1   = ls_b[bank_add(c1_r.bank, BANK_W'(4))];
  assign vp1   = ls_b[bank_add(c1_r.bank, BANK_W'(1))];
  assign vp2   = ls_b[bank_add(c1_r.bank, BANK_W'(2))];

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= emit;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) out_valid_r <= v3_r;
    end
  end

  // payload through the stages; advance the row history once per result
  always_ff @(posedge clk) begin
    if (en1) begin
      c1_r <= ctrl0;
    end
    if (en2) begin
      c2_r     <= c1_r;
      dt2_re_r <= OUT_W'($signed(dd_rd[2*T_W-1:T_W]));
      dt2_im_r <= OUT_W'($signed(dd_rd[T_W-1:0]));
    end
    if (v1_r && en2) begin
      ha1_r <= sel_a;
      hb1_r <= sel_b;
      hb2_r <= hb1_r;
    end
    if (en3) begin
      c3_r     <= c2_r;
      dt3_re_r <= dt2_re_r;
      dt3_im_r <= dt2_im_r;
    end
    if (en4) begin
      gt_re_r     <= dt3_re_r;
      gt_im_r     <= dt3_im_r;
      frame_end_r <= c3_r.frame_end;
    end
  end

  csg_stencil #(.SAMPLE_BITS(SB)) u_gx_re (
    .clk(clk), .en(sen),
    .a($signed(hb2_r[D_W-1:SB])), .b($signed(hb1_r[D_W-1:SB])),
    .c($signed(ha1_r[D_W-1:SB])), .d($signed(sel_a[D_W-1:SB])),
    .keep(c3_r.interior), .res(out_m.gx_re)
  );

  csg_stencil #(.SAMPLE_BITS(SB)) u_gx_im (
    .clk(clk), .en(sen),
    .a($signed(hb2_r[SB-1:0])), .b($signed(hb1_r[SB-1:0])),
    .c($signed(ha1_r[SB-1:0])), .d($signed(sel_a[SB-1:0])),
    .keep(c3_r.interior), .res(out_m.gx_im)
  );

  csg_stencil #(.SAMPLE_BITS(SB)) u_gy_re (
    .clk(clk), .en(sen),
    .a($signed(vm2[D_W-1:SB])), .b($signed(vm1[D_W-1:SB])),
    .c($signed(vp1[D_W-1:SB])), .d($signed(vp2[D_W-1:SB])),
    .keep(c3_r.interior), .res(out_m.gy_re)
  );

  csg_stencil #(.SAMPLE_BITS(SB)) u_gy_im (
    .clk(clk), .en(sen),
    .a($signed(vm2[SB-1:0])), .b($signed(vm1[SB-1:0])),
    .c($signed(vp1[SB-1:0])), .d($signed(vp2[SB-1:0])),
    .keep(c3_r.interior), .res(out_m.gy_im)
  );

  assign out_m.valid     = out_valid_r;
  assign out_m.gt_re     = gt_re_r;
  assign out_m.gt_im     = gt_im_r;
  assign out_m.frame_end = frame_end_r;

endmodule

>>> sim/csg_gradient_checker.sv
// Checker for the gradient unit: watches the pixel, result and register ports,
// predicts each result beat and compares it field by field.
// Depends on csg_pkg, csg_in_if and csg_out_if.
module csg_gradient_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  csg_in_if                             in_c,
  csg_out_if                            out_c,
  input  logic                          cfg_we,
  input  logic [csg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csg_pkg::CFG_W-1:0]     cfg_data,
  output int                            fail_count,
  output int                            results_due,
  output int                            diffs_held
);
  import csg_pkg::*;

  localparam int ROW_CAP = 1024;
  localparam int RING    = 2 * ROW_CAP + 3;

  typedef struct packed {
    logic signed [OUT_W-1:0] gx_re;
    logic signed [OUT_W-1:0] gx_im;
    logic signed [OUT_W-1:0] gy_re;
    logic signed [OUT_W-1:0] gy_im;
    logic signed [OUT_W-1:0] gt_re;
    logic signed [OUT_W-1:0] gt_im;
    logic                    frame_end;
  } grad_beat_t;

  grad_beat_t        grad_due[$];
  logic [CFG_W-1:0]  width_reg, height_reg;
  logic signed [15:0] px_re [0:LINES*ROW_CAP-1];
  logic signed [15:0] px_im [0:LINES*ROW_CAP-1];
  logic signed [OUT_W-1:0] dt_re [0:RING-1];
  logic signed [OUT_W-1:0] dt_im [0:RING-1];
  int ring_head, held, in_col, in_row, out_col, out_row;

  assign results_due = grad_due.size();
  assign diffs_held  = held;

  function automatic int dim(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    return (v > ROW_CAP) ? ROW_CAP : int'(v);
  endfunction

  function automatic int slot(int r, int c);
    return (r % LINES) * ROW_CAP + (c % ROW_CAP);
  endfunction

  function automatic int five_point(int a, int b, int c, int d);
    return (a - 8 * b + 8 * c - d) / 12;  // truncates toward zero
  endfunction

  task automatic restart_raster();
    ring_head = 0; held = 0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endtask

  // Pop the oldest held difference and build the gradient beat for out position.
  task automatic produce_grad();
    int w, h, r, c, tail;
    grad_beat_t g;
    w = dim(width_reg); h = dim(height_reg);
    r = out_row; c = out_col;
    tail = (ring_head + RING - held) % RING;
    g = '0;
    if (c >= 2 && c + 2 < w && r >= 2 && r + 2 < h) begin
      g.gx_re = OUT_W'(five_point(px_re[slot(r, c-2)], px_re[slot(r, c-1)],
                                  px_re[slot(r, c+1)], px_re[slot(r, c+2)]));
      g.gx_im = OUT_W'(five_point(px_im[slot(r, c-2)], px_im[slot(r, c-1)],
                                  px_im[slot(r, c+1)], px_im[slot(r, c+2)]));
      g.gy_re = OUT_W'(five_point(px_re[slot(r-2, c)], px_re[slot(r-1, c)],
                                  px_re[slot(r+1, c)], px_re[slot(r+2, c)]));
      g.gy_im = OUT_W'(five_point(px_im[slot(r-2, c)], px_im[slot(r-1, c)],
                                  px_im[slot(r+1, c)], px_im[slot(r+2, c)]));
    end
    g.gt_re = dt_re[tail];
    g.gt_im = dt_im[tail];
    g.frame_end = (r + 1 >= h) && (c + 1 >= w);
    held--;
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) out_row = 0;
    end
    grad_due.push_back(g);
  endtask

  task automatic take_beat();
    int w, h, idx;
    w = dim(width_reg); h = dim(height_reg);
    if (in_c.action == ACT_FLUSH) begin
      if (held != 0) produce_grad();
      return;
    end
    idx = slot(in_row, in_col);
    px_re[idx] = in_c.curr_re;
    px_im[idx] = in_c.curr_im;
    dt_re[ring_head] = OUT_W'(int'(in_c.curr_re) - int'(in_c.prev_re));
    dt_im[ring_head] = OUT_W'(int'(in_c.curr_im) - int'(in_c.prev_im));
    ring_head = (ring_head + 1) % RING;
    if (held < RING) held++;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
      if (in_row >= h) in_row = 0;
    end
    if (held > 2 * w + 2) produce_grad();
  endtask

  task automatic check_field(string name, logic signed [OUT_W-1:0] exp_v,
                             logic signed [OUT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    grad_beat_t g;
    if (!rst_n) begin
      width_reg  = 11'd1024;
      height_reg = 11'd1024;
      fail_count = 0;
      grad_due.delete();
      restart_raster();
    end else begin
      // result first: it can never stem from an input beat of this same edge
      if (out_c.valid && out_c.ready) begin
        if (grad_due.size() == 0) begin
          $error("result beat with no result due");
          fail_count++;
        end else begin
          g = grad_due.pop_front();
          check_field("gx_re", g.gx_re, out_c.gx_re);
          check_field("gx_im", g.gx_im, out_c.gx_im);
          check_field("gy_re", g.gy_re, out_c.gy_re);
          check_field("gy_im", g.gy_im, out_c.gy_im);
          check_field("gt_re", g.gt_re, out_c.gt_re);
          check_field("gt_im", g.gt_im, out_c.gt_im);
          if (g.frame_end !== out_c.frame_end) begin
            $error("frame_end: expected %0d, got %0d", g.frame_end, out_c.frame_end);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          width_reg = cfg_data;
          restart_raster();
        end else if (cfg_index == REG_FRAME_HEIGHT) begin
          height_reg = cfg_data;
          restart_raster();
        end
      end
      if (in_c.valid && in_c.ready) take_beat();
    end
  end

endmodule

>>> sim/complex_spatiotemporal_gradient_unit_tb.sv
// Testbench top for the gradient unit: clock, reset, pixel and flush stimulus,
// register writes and the verdict. Depends on csg_pkg, both channel interfaces,
// the unit itself and csg_gradient_checker.
module complex_spatiotemporal_gradient_unit_tb;
  import csg_pkg::*;

  localparam int ROW_CAP = 1024;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;
  int fail_count, results_due, diffs_held;
  int beats_taken = 0;
  int idle_pct = 0, stall_pct = 0;

  // Raster position and line-store fill as the stimulus side sees them.
  int frame_w = ROW_CAP, frame_h = ROW_CAP, pix_col = 0, pix_row = 0;
  bit line_seen [0:LINES*ROW_CAP-1];

  csg_in_if  in_c();
  csg_out_if out_c();

  complex_spatiotemporal_gradient_unit dut (
    .clk(clk), .rst_n(rst_n), .in_s(in_c), .out_m(out_c),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  csg_gradient_checker grad_chk (
    .clk(clk), .rst_n(rst_n), .in_c(in_c), .out_c(out_c),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .results_due(results_due), .diffs_held(diffs_held)
  );

  always #10 clk = ~clk;

  // Count accepted input beats on the edge itself; the sender polls this at negedge.
  always @(posedge clk) begin
    if (in_c.valid && in_c.ready) beats_taken <= beats_taken + 1;
  end

  // Receiver: stall at random with the current phase's rate.
  always @(negedge clk) begin
    out_c.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    in_c.valid = 1'b0; in_c.action = 1'b0;
    in_c.curr_re = '0; in_c.curr_im = '0; in_c.prev_re = '0; in_c.prev_im = '0;
    out_c.ready = 1'b0;
  end

  function automatic int dim(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    return (v > ROW_CAP) ? ROW_CAP : int'(v);
  endfunction

  // Mostly random samples, with the range ends mixed in.
  function automatic logic signed [15:0] sample();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // A mid-frame flush reads the line store only where it has been filled.
  function automatic bit flush_safe();
    if (frame_w < 5 || frame_h < 5) return 1'b1;
    for (int r = 0; r < LINES; r++)
      for (int c = 0; c < frame_w; c++)
        if (!line_seen[r * ROW_CAP + c]) return 1'b0;
    return 1'b1;
  endfunction

  // Send one beat after a random gap; return at the negedge after it was taken.
  task automatic send_beat(logic act, logic signed [15:0] cr, logic signed [15:0] ci,
                           logic signed [15:0] pr, logic signed [15:0] pi);
    int target;
    while ($urandom_range(99) < idle_pct) begin
      in_c.valid <= 1'b0;
      @(negedge clk);
    end
    in_c.valid <= 1'b1; in_c.action <= act;
    in_c.curr_re <= cr; in_c.curr_im <= ci; in_c.prev_re <= pr; in_c.prev_im <= pi;
    target = beats_taken + 1;
    do @(negedge clk); while (beats_taken != target);
    if (act != ACT_FLUSH) begin
      line_seen[(pix_row % LINES) * ROW_CAP + pix_col] = 1'b1;
      pix_col++;
      if (pix_col >= frame_w) begin
        pix_col = 0;
        pix_row++;
        if (pix_row >= frame_h) pix_row = 0;
      end
    end
  endtask

  task automatic send_pixel();
    send_beat(1'b0, sample(), sample(), sample(), sample());
  endtask

  task automatic send_flush();
    send_beat(ACT_FLUSH, sample(), sample(), sample(), sample());
  endtask

  // Drain every held difference; at a frame end these are all border pixels.
  task automatic drain_all();
    while (diffs_held > 0) send_flush();
  endtask

  // Hold the sender until every due result is out, then let the pipe settle.
  task automatic wait_idle();
    in_c.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    wait_idle();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH) frame_w = dim(val);
    if (idx == REG_FRAME_HEIGHT) frame_h = dim(val);
    if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
      pix_col = 0;
      pix_row = 0;
    end
  endtask

  task automatic set_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    if ($urandom_range(1)) begin
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
    end else begin
      write_reg(REG_FRAME_HEIGHT, h);
      write_reg(REG_FRAME_WIDTH, w);
    end
  endtask

  // One random phase: well-formed frames with random content, occasional
  // mid-frame flushes and drains at some frame ends.
  task automatic random_phase(int beats);
    int start, frames;
    logic [CFG_W-1:0] w, h;
    start = beats_taken;
    while (beats_taken - start < beats) begin
      case ($urandom_range(19))
        0: begin w = 11'($urandom_range(0, 2)); h = 11'($urandom_range(0, 12)); end
        1: begin w = 11'($urandom_range(5, 12)); h = 11'($urandom_range(5, 8)); end
        2: begin w = 11'($urandom_range(12, 16)); h = 11'($urandom_range(1, 2)); end
        3: begin w = 11'd0; h = 11'd0; end
        default: begin
          w = 11'($urandom_range(1, 12));
          h = 11'($urandom_range(1, 8));
        end
      endcase
      set_frame(w, h);
      frames = $urandom_range(1, 2);
      for (int f = 0; f < frames; f++) begin
        for (int p = 0; p < frame_w * frame_h; p++) begin
          if ($urandom_range(24) == 0 && flush_safe()) send_flush();
          send_pixel();
        end
        if ($urandom_range(1)) drain_all();
      end
    end
    drain_all();
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset size, extreme samples; output row 0 is all border.
    send_beat(1'b0, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    send_beat(1'b0, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_beat(1'b0, 16'sh0000, 16'shffff, 16'sh0001, 16'sh8000);
    send_beat(1'b0, 16'shaaaa, 16'sh5555, 16'sh5555, 16'shaaaa);
    repeat (5) send_flush();  // the last one finds nothing held

    // Zero width reads as one, oversized height saturates; an unused index.
    set_frame(11'd0, 11'd2047);
    repeat (4) send_pixel();
    drain_all();
    send_flush();
    write_reg(2'd3, 11'h7ff);

    // Oversized width saturates; a short stretch of one row, then drain.
    set_frame(11'd2047, 11'd1);
    repeat (6) send_pixel();
    drain_all();

    // Five by five: one interior pixel, with extreme samples around it.
    set_frame(11'd5, 11'd5);
    for (int r = 0; r < 5; r++)
      for (int c = 0; c < 5; c++)
        send_beat(1'b0, (c < 2) ^ (c == 0) ? 16'sh8000 : 16'sh7fff,
                  (r < 2) ^ (r == 0) ? 16'sh7fff : 16'sh8000,
                  16'sh7fff, 16'sh8000);
    drain_all();

    idle_pct = 0;  stall_pct = 0;  random_phase(80);
    idle_pct = 82; stall_pct = 0;  random_phase(80);
    idle_pct = 0;  stall_pct = 82; random_phase(80);
    idle_pct = 10; stall_pct = 10; random_phase(80);

    wait_idle();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(20 * 2000000);
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
src/csg_pkg.sv
src/csg_in_if.sv
src/csg_out_if.sv
src/csg_line_store.sv
src/csg_diff_delay.sv
src/csg_stencil.sv
src/complex_spatiotemporal_gradient_unit.sv
sim/csg_gradient_checker.sv
sim/complex_spatiotemporal_gradient_unit_tb.sv
